// File: src/mdct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_pkg
// Shared types and constants of the drum channel tracker: synth modes, reset
// message images and the classified item handed from front to back.
// ----------------------------------------------------------------------------
package mdct_pkg;

  localparam int CHANNEL_COUNT   = 16;
  localparam int MODULE_COUNT    = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int STORE_DEPTH     = 11;
  localparam int STORE_CNT_W     = $clog2(STORE_DEPTH + 1);

  // synth modes
  typedef enum logic [1:0] {
    MODE_GM  = 2'd0,
    MODE_GM2 = 2'd1,
    MODE_GS  = 2'd2,
    MODE_XG  = 2'd3
  } mode_t;

  // status kinds and special byte values
  localparam logic [3:0] KIND_CONTROL = 4'hB;
  localparam logic [3:0] KIND_PROGRAM = 4'hC;
  localparam logic [3:0] KIND_SYSTEM  = 4'hF;
  localparam logic [6:0] XG_DRUM_BANK  = 7'd127;
  localparam logic [6:0] GM2_DRUM_BANK = 7'd120;
  localparam logic [6:0] GM2_MELO_BANK = 7'd121;

  localparam logic [7:0] SX_START     = 8'hF0;
  localparam logic [7:0] SX_STOP      = 8'hF7;
  localparam logic [7:0] ID_ROLAND    = 8'h41;
  localparam logic [7:0] GS_MODEL     = 8'h42;
  localparam logic [7:0] GS_DT1       = 8'h12;
  localparam logic [7:0] GS_ADDR_HI   = 8'h40;
  localparam logic [7:0] GS_PART_GRP  = 8'h10;
  localparam logic [7:0] GS_PART_ASGN = 8'h02;
  localparam logic [7:0] GS_RHYTHM    = 8'h15;

  // drum state after a reset
  localparam logic [15:0] DEFAULT_MASK = 16'h0200;
  localparam logic [7:0] DEFAULT_MAP [CHANNEL_COUNT] = '{
    8'd9, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
    8'd7, 8'd8, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15
  };

  // reset message images
  localparam logic [7:0] GM_RESET_MSG [6] = '{
    8'hF0, 8'h7E, 8'h7F, 8'h09, 8'h01, 8'hF7
  };
  localparam logic [7:0] GM2_RESET_MSG [6] = '{
    8'hF0, 8'h7E, 8'h7F, 8'h09, 8'h03, 8'hF7
  };
  localparam logic [7:0] GS_RESET_MSG [11] = '{
    8'hF0, 8'h41, 8'h10, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7F, 8'h00, 8'h41, 8'hF7
  };
  localparam logic [7:0] XG_RESET_MSG [9] = '{
    8'hF0, 8'h43, 8'h10, 8'h4C, 8'h00, 8'h00, 8'h7E, 8'h00, 8'hF7
  };

  // classified item, front to back
  typedef struct packed {
    logic       is_sysex;
    logic [3:0] ch;
    logic       bank_sel;
    logic       val_127;
    logic       val_120;
    logic       val_121;
    logic       prog;
    logic       rst_hit;
    mode_t      rst_mode;
    logic       gs_edit;
    logic       edit_map;
    logic       edit_rhythm;
    logic [3:0] part;
    logic [7:0] value;
  } op_t;

endpackage

// File: src/mdct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_front
// Accepts items, collects sysex bytes and classifies each item that yields a
// result into a compact operation for the back part.
// ----------------------------------------------------------------------------
module mdct_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             command,
  input  logic [7:0]       status_byte,
  input  logic [6:0]       data_one,
  input  logic [6:0]       data_two,
  input  logic             sysex_end,
  input  logic             q_full,
  output logic             q_push,
  output mdct_pkg::op_t    q_data
);

  localparam int CW = mdct_pkg::STORE_CNT_W;

  logic [7:0]    store [mdct_pkg::STORE_DEPTH];
  logic [CW-1:0] count;
  logic          overflow;
  logic          accept;
  logic          room;
  logic [7:0]    sx [mdct_pkg::STORE_DEPTH];
  logic [CW-1:0] n;
  logic          ovf;
  logic          gm_hit, gm2_hit, gs_hit, xg_hit;
  logic [7:0]    csum;
  logic          chan_status;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign room   = count < CW'(mdct_pkg::STORE_DEPTH);

  // sysex byte store and length tracking
  always_ff @(posedge clk) begin
    if (accept && command && room) begin
      store[count[$clog2(mdct_pkg::STORE_DEPTH)-1:0]] <= status_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept && command) begin
      if (sysex_end) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (room) begin
        count <= count + CW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // view of the message including the byte now arriving
  always_comb begin
    for (int i = 0; i < mdct_pkg::STORE_DEPTH; i++) begin
      sx[i] = (room && count == CW'(i)) ? status_byte : store[i];
    end
    n   = room ? count + CW'(1) : count;
    ovf = overflow || !room;
  end

  // reset message matches
  always_comb begin
    gm_hit  = !ovf && n == CW'(6);
    gm2_hit = !ovf && n == CW'(6);
    for (int i = 0; i < 6; i++) begin
      gm_hit  = gm_hit  && sx[i] == mdct_pkg::GM_RESET_MSG[i];
      gm2_hit = gm2_hit && sx[i] == mdct_pkg::GM2_RESET_MSG[i];
    end
    xg_hit = !ovf && n == CW'(9);
    for (int i = 0; i < 9; i++) begin
      xg_hit = xg_hit && sx[i] == mdct_pkg::XG_RESET_MSG[i];
    end
    csum   = {1'b0, 7'(sx[5] + sx[6] + 8'd1)};
    gs_hit = !ovf && n == CW'(11) && csum == sx[9] &&
             sx[7] == mdct_pkg::GS_RESET_MSG[7] && sx[8] == mdct_pkg::GS_RESET_MSG[8] &&
             sx[10] == mdct_pkg::GS_RESET_MSG[10];
    for (int i = 0; i < 5; i++) begin
      gs_hit = gs_hit && sx[i] == mdct_pkg::GS_RESET_MSG[i];
    end
  end

  // classification
  always_comb begin
    chan_status = status_byte[7] && status_byte[7:4] != mdct_pkg::KIND_SYSTEM;
    q_push      = accept && (command ? sysex_end : chan_status);

    q_data          = '0;
    q_data.is_sysex = command;
    q_data.ch       = status_byte[3:0];
    q_data.bank_sel = status_byte[7:4] == mdct_pkg::KIND_CONTROL && data_one == 7'd0;
    q_data.val_127  = data_two == mdct_pkg::XG_DRUM_BANK;
    q_data.val_120  = data_two == mdct_pkg::GM2_DRUM_BANK;
    q_data.val_121  = data_two == mdct_pkg::GM2_MELO_BANK;
    q_data.prog     = status_byte[7:4] == mdct_pkg::KIND_PROGRAM;
    q_data.rst_hit  = gm_hit || gm2_hit || gs_hit || xg_hit;
    if (gm_hit) begin
      q_data.rst_mode = mdct_pkg::MODE_GM;
    end else if (gm2_hit) begin
      q_data.rst_mode = mdct_pkg::MODE_GM2;
    end else if (gs_hit) begin
      q_data.rst_mode = mdct_pkg::MODE_GS;
    end else begin
      q_data.rst_mode = mdct_pkg::MODE_XG;
    end
    q_data.gs_edit  = !ovf && n == CW'(11) &&
                      sx[0] == mdct_pkg::SX_START && sx[1] == mdct_pkg::ID_ROLAND &&
                      sx[3] == mdct_pkg::GS_MODEL && sx[4] == mdct_pkg::GS_DT1 &&
                      sx[5] == mdct_pkg::GS_ADDR_HI &&
                      sx[6][7:4] == mdct_pkg::GS_PART_GRP[7:4] &&
                      sx[10] == mdct_pkg::SX_STOP;
    q_data.edit_map    = sx[7] == mdct_pkg::GS_PART_ASGN;
    q_data.edit_rhythm = sx[7] == mdct_pkg::GS_RHYTHM;
    q_data.part        = sx[6][3:0];
    q_data.value       = sx[8];
  end

endmodule

// File: src/mdct_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module mdct_queue #(
  parameter int DEPTH = mdct_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mdct_pkg::op_t  wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output mdct_pkg::op_t  rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mdct_pkg::op_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = fill == CW'(DEPTH);
  assign q_empty = fill == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: src/mdct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_back
// Carries out operations on mode, drum mask and part map and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
module mdct_back #(
  parameter int MODULE_COUNT = mdct_pkg::MODULE_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mdct_pkg::op_t  q_data,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           result_kind,
  output logic [3:0]     channel,
  output logic [2:0]     primary_module,
  output logic [2:0]     secondary_module,
  output logic           send_secondary,
  output logic           drum_update,
  output logic [15:0]    drum_mask,
  output logic [1:0]     mode,
  output logic           reset_seen
);

  mdct_pkg::mode_t synth_mode, synth_mode_next;
  logic [15:0]     flags, flags_next;
  logic [7:0]      part_map [mdct_pkg::CHANNEL_COUNT];
  logic [7:0]      map_ch;
  logic            out_valid;
  logic [2:0]      prim_tab [mdct_pkg::CHANNEL_COUNT];
  logic [2:0]      sec_tab  [mdct_pkg::CHANNEL_COUNT];

  // module routing tables, fixed at elaboration
  for (genvar c = 0; c < mdct_pkg::CHANNEL_COUNT; c++) begin : g_route
    assign prim_tab[c] = 3'((c * 2) % MODULE_COUNT);
    assign sec_tab[c]  = 3'((c * 2 + 1) % MODULE_COUNT);
  end

  assign q_pop  = !q_empty && (!out_valid || pop);
  assign empty  = !out_valid;
  assign map_ch = part_map[q_data.part];

  // state update for the operation at the queue head
  always_comb begin
    synth_mode_next = synth_mode;
    flags_next      = flags;
    if (q_data.is_sysex) begin
      if (q_data.rst_hit) begin
        synth_mode_next = q_data.rst_mode;
        flags_next      = mdct_pkg::DEFAULT_MASK;
      end else if (q_data.gs_edit && synth_mode == mdct_pkg::MODE_GS &&
                   !q_data.edit_map && q_data.edit_rhythm &&
                   map_ch < 8'(mdct_pkg::CHANNEL_COUNT)) begin
        flags_next[map_ch[3:0]] = q_data.value != 8'd0;
      end
    end else if (q_data.bank_sel) begin
      if (synth_mode == mdct_pkg::MODE_XG) begin
        flags_next[q_data.ch] = q_data.val_127;
      end else if (synth_mode == mdct_pkg::MODE_GM2) begin
        if (q_data.val_120) begin
          flags_next[q_data.ch] = 1'b1;
        end else if (q_data.val_121) begin
          flags_next[q_data.ch] = 1'b0;
        end
      end
    end
  end

  // tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      synth_mode <= mdct_pkg::MODE_GM;
      flags      <= mdct_pkg::DEFAULT_MASK;
      part_map   <= mdct_pkg::DEFAULT_MAP;
    end else if (q_pop) begin
      synth_mode <= synth_mode_next;
      flags      <= flags_next;
      if (q_data.is_sysex && q_data.rst_hit) begin
        part_map <= mdct_pkg::DEFAULT_MAP;
      end else if (q_data.is_sysex && q_data.gs_edit && q_data.edit_map &&
                   synth_mode == mdct_pkg::MODE_GS) begin
        part_map[q_data.part] <= q_data.value;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_kind <= q_data.is_sysex;
      drum_mask   <= flags_next;
      mode        <= synth_mode_next;
      if (q_data.is_sysex) begin
        channel          <= '0;
        primary_module   <= '0;
        secondary_module <= '0;
        send_secondary   <= 1'b0;
        drum_update      <= 1'b0;
        reset_seen       <= q_data.rst_hit;
      end else begin
        channel          <= q_data.ch;
        primary_module   <= prim_tab[q_data.ch];
        secondary_module <= sec_tab[q_data.ch];
        send_secondary   <= !flags_next[q_data.ch];
        drum_update      <= q_data.prog;
        reset_seen       <= 1'b0;
      end
    end
  end

endmodule

// File: src/midi_drum_channel_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_drum_channel_tracker_unit
// Tracks synth mode, drum channels and the GS part map from MIDI short
// messages and sysex bytes, and routes channel messages to modules.
// ----------------------------------------------------------------------------
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | command status_byte data_one data_two
//            |                  | sysex_end
//   result   | empty / pop      | result_kind channel primary_module
//            |                  | secondary_module send_secondary drum_update
//            |                  | drum_mask mode reset_seen
//
// One item per cycle sustained while results are popped. An item that yields a
// result is written into the operation queue when it is taken; the back update
// runs when it is popped, and the result then lands in the output register.
// Synchronous reset restores GM mode, the default drum mask and part map.
// Full rises only when the front queue fills because results are not popped.
// ----------------------------------------------------------------------------
module midi_drum_channel_tracker_unit #(
  parameter int MODULE_COUNT = mdct_pkg::MODULE_COUNT,
  parameter int QUEUE_DEPTH  = mdct_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  data_one,
  input  logic [6:0]  data_two,
  input  logic        sysex_end,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [3:0]  channel,
  output logic [2:0]  primary_module,
  output logic [2:0]  secondary_module,
  output logic        send_secondary,
  output logic        drum_update,
  output logic [15:0] drum_mask,
  output logic [1:0]  mode,
  output logic        reset_seen
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  mdct_pkg::op_t q_wdata;
  mdct_pkg::op_t q_rdata;

  // front: accept and classify
  mdct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .sysex_end   (sysex_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // operation queue
  mdct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_rdata)
  );

  // back: state update and result register
  mdct_back #(
    .MODULE_COUNT (MODULE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .result_kind      (result_kind),
    .channel          (channel),
    .primary_module   (primary_module),
    .secondary_module (secondary_module),
    .send_secondary   (send_secondary),
    .drum_update      (drum_update),
    .drum_mask        (drum_mask),
    .mode             (mode),
    .reset_seen       (reset_seen)
  );

endmodule

// File: tb/sv/mdct_route_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_route_checker
// Watches the input and result ports of the drum channel tracker. Every accepted item
// runs through a local copy of the mode, drum mask and part map tracking,
// the routed results it yields are queued, and each popped result is
// compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module mdct_route_checker
  import mdct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        command,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  data_one,
  input  logic [6:0]  data_two,
  input  logic        sysex_end,
  input  logic        empty,
  input  logic        pop,
  input  logic        result_kind,
  input  logic [3:0]  channel,
  input  logic [2:0]  primary_module,
  input  logic [2:0]  secondary_module,
  input  logic        send_secondary,
  input  logic        drum_update,
  input  logic [15:0] drum_mask,
  input  logic [1:0]  mode,
  input  logic        reset_seen,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          resets_seen
);

  // one routed or sysex result as the block presents it
  typedef struct packed {
    logic        kind;
    logic [3:0]  ch;
    logic [2:0]  prim;
    logic [2:0]  sec;
    logic        send2;
    logic        upd;
    logic [15:0] mask;
    logic [1:0]  mode;
    logic        rst_hit;
  } route_t;

  route_t      route_q [$];

  // tracked state
  mode_t       cur_mode;
  logic [15:0] drums;
  logic [7:0]  pmap [CHANNEL_COUNT];
  logic [7:0]  sx_buf [STORE_DEPTH];
  int          sx_len;
  logic        sx_ovf;

  int          fails;
  int          n_checked;
  int          n_resets;

  function automatic void set_drum(input logic [3:0] ch, input logic on);
    drums[ch] = on;
  endfunction

  // evaluate a completed sysex, returns 1 on a recognized reset
  function automatic logic finish_message();
    logic       hit_gm;
    logic       hit_gm2;
    logic       hit_gs;
    logic       hit_xg;
    logic [3:0] part;
    logic [7:0] tgt;
    int         i;
    if (sx_ovf) return 1'b0;
    hit_gm  = (sx_len == 6);
    hit_gm2 = (sx_len == 6);
    hit_xg  = (sx_len == 9);
    hit_gs  = (sx_len == STORE_DEPTH);
    if (sx_len == 6) begin
      for (i = 0; i < 6; i++) begin
        if (sx_buf[i] != GM_RESET_MSG[i]) hit_gm = 1'b0;
        if (sx_buf[i] != GM2_RESET_MSG[i]) hit_gm2 = 1'b0;
      end
    end
    if (sx_len == 9) begin
      for (i = 0; i < 9; i++) begin
        if (sx_buf[i] != XG_RESET_MSG[i]) hit_xg = 1'b0;
      end
    end
    // gs reset: fixed header and data, address bytes free but checksummed
    if (sx_len == STORE_DEPTH) begin
      for (i = 0; i < 5; i++) begin
        if (sx_buf[i] != GS_RESET_MSG[i]) hit_gs = 1'b0;
      end
      if (sx_buf[7] != GS_RESET_MSG[7] || sx_buf[8] != GS_RESET_MSG[8]) hit_gs = 1'b0;
      if (((int'(sx_buf[5]) + int'(sx_buf[6]) + 1) & 127) != int'(sx_buf[9])) hit_gs = 1'b0;
      if (sx_buf[10] != GS_RESET_MSG[10]) hit_gs = 1'b0;
    end

    if (hit_gm || hit_gm2 || hit_gs || hit_xg) begin
      drums = DEFAULT_MASK;
      pmap  = DEFAULT_MAP;
      if (hit_gm) cur_mode = MODE_GM;
      else if (hit_gm2) cur_mode = MODE_GM2;
      else if (hit_gs) cur_mode = MODE_GS;
      else cur_mode = MODE_XG;
      return 1'b1;
    end

    // gs part assign and rhythm edits, only while in gs mode
    if (cur_mode == MODE_GS && sx_len == STORE_DEPTH &&
        sx_buf[0] == SX_START && sx_buf[1] == ID_ROLAND && sx_buf[3] == GS_MODEL &&
        sx_buf[4] == GS_DT1 && sx_buf[5] == GS_ADDR_HI &&
        sx_buf[6][7:4] == GS_PART_GRP[7:4] && sx_buf[10] == SX_STOP) begin
      part = sx_buf[6][3:0];
      if (sx_buf[7] == GS_PART_ASGN) begin
        pmap[part] = sx_buf[8];
      end else if (sx_buf[7] == GS_RHYTHM) begin
        tgt = pmap[part];
        if (tgt < CHANNEL_COUNT) set_drum(tgt[3:0], sx_buf[8] != 8'd0);
      end
    end
    return 1'b0;
  endfunction

  // run one accepted item through the tracker, queue its result if any
  task automatic predict_item(input logic cmd, input logic [7:0] sb,
                              input logic [6:0] d1, input logic [6:0] d2,
                              input logic eom);
    route_t     r;
    logic [3:0] ch;
    r = '0;
    if (cmd) begin
      if (sx_len < STORE_DEPTH) begin
        sx_buf[sx_len] = sb;
        sx_len++;
      end else begin
        sx_ovf = 1'b1;
      end
      if (eom) begin
        r.rst_hit = finish_message();
        sx_len    = 0;
        sx_ovf    = 1'b0;
        r.kind    = 1'b1;
        r.mask    = drums;
        r.mode    = cur_mode;
        route_q.push_back(r);
      end
    end else if (sb[7] && sb[7:4] != KIND_SYSTEM) begin
      ch = sb[3:0];
      if (sb[7:4] == KIND_CONTROL && d1 == 7'd0) begin
        if (cur_mode == MODE_XG) begin
          set_drum(ch, d2 == XG_DRUM_BANK);
        end else if (cur_mode == MODE_GM2) begin
          if (d2 == GM2_DRUM_BANK) set_drum(ch, 1'b1);
          else if (d2 == GM2_MELO_BANK) set_drum(ch, 1'b0);
        end
      end else if (sb[7:4] == KIND_PROGRAM) begin
        r.upd = 1'b1;
      end
      r.ch    = ch;
      r.prim  = 3'((int'(ch) * 2) % MODULE_COUNT);
      r.sec   = 3'((int'(ch) * 2 + 1) % MODULE_COUNT);
      r.send2 = ~drums[ch];
      r.mask  = drums;
      r.mode  = cur_mode;
      route_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  // compare popped results, then predict the item taken at this edge
  always @(posedge clk) begin
    route_t want;
    if (rst) begin
      cur_mode = MODE_GM;
      drums    = DEFAULT_MASK;
      pmap     = DEFAULT_MAP;
      sx_len   = 0;
      sx_ovf   = 1'b0;
      route_q.delete();
      fails     = 0;
      n_checked = 0;
      n_resets  = 0;
    end else begin
      if (pop && !empty) begin
        if (route_q.size() == 0) begin
          $error("result popped with no item waiting");
          fails++;
        end else begin
          want = route_q.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("channel", want.ch, channel);
          check_field("primary_module", want.prim, primary_module);
          check_field("secondary_module", want.sec, secondary_module);
          check_field("send_secondary", want.send2, send_secondary);
          check_field("drum_update", want.upd, drum_update);
          check_field("drum_mask", want.mask, drum_mask);
          check_field("mode", want.mode, mode);
          check_field("reset_seen", want.rst_hit, reset_seen);
          n_checked++;
          if (want.rst_hit) n_resets++;
        end
      end
      if (push && !full) predict_item(command, status_byte, data_one, data_two, sysex_end);
    end
    fail_count  <= fails;
    pending     <= route_q.size();
    checked     <= n_checked;
    resets_seen <= n_resets;
  end

endmodule

// File: tb/sv/midi_drum_channel_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_drum_channel_tracker_unit_tb
// Drives short messages and sysex streams into the drum channel tracker with
// random gaps on the input and random pop stalls on the result side. A short
// directed run hits edge values and mode switches, then a random mix of
// resets, gs edits, bank selects, overflows and broken messages follows.
// The route checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module midi_drum_channel_tracker_unit_tb;
  import mdct_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        command = 1'b0;
  logic [7:0]  status_byte = 8'd0;
  logic [6:0]  data_one = 7'd0;
  logic [6:0]  data_two = 7'd0;
  logic        sysex_end = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        result_kind;
  logic [3:0]  channel;
  logic [2:0]  primary_module;
  logic [2:0]  secondary_module;
  logic        send_secondary;
  logic        drum_update;
  logic [15:0] drum_mask;
  logic [1:0]  mode;
  logic        reset_seen;

  int          fail_count;
  int          pending;
  int          checked;
  int          resets_seen;

  int          items_sent = 0;
  int          ignored_sent = 0;
  int          sysex_sent = 0;
  logic        no_idle = 1'b0;
  logic [7:0]  sx_msg [$];

  midi_drum_channel_tracker_unit u_dut (.*);

  mdct_route_checker u_check (.*);

  always #1 clk = ~clk;

  // offer one item after a random gap and hold it until taken
  task automatic send_item(input logic cmd, input logic [7:0] sb, input logic [6:0] d1,
                           input logic [6:0] d2, input logic eom);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    command     <= cmd;
    status_byte <= sb;
    data_one    <= d1;
    data_two    <= d2;
    sysex_end   <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // stream the prepared sysex bytes, end flag on the last one
  task automatic send_sysex_msg();
    int i;
    for (i = 0; i < sx_msg.size(); i++) begin
      send_item(1'b1, sx_msg[i], 7'($urandom), 7'($urandom), i == sx_msg.size() - 1);
    end
    sysex_sent++;
  endtask

  task automatic load_reset(input mode_t m);
    sx_msg.delete();
    case (m)
      MODE_GM:  foreach (GM_RESET_MSG[i]) sx_msg.push_back(GM_RESET_MSG[i]);
      MODE_GM2: foreach (GM2_RESET_MSG[i]) sx_msg.push_back(GM2_RESET_MSG[i]);
      MODE_GS:  foreach (GS_RESET_MSG[i]) sx_msg.push_back(GS_RESET_MSG[i]);
      default:  foreach (XG_RESET_MSG[i]) sx_msg.push_back(XG_RESET_MSG[i]);
    endcase
  endtask

  // gs parameter write to a part, sometimes with one broken byte
  task automatic build_gs_edit(input logic [7:0] op, input logic [7:0] val);
    sx_msg.delete();
    sx_msg.push_back(SX_START);
    sx_msg.push_back(ID_ROLAND);
    sx_msg.push_back(8'($urandom));
    sx_msg.push_back(GS_MODEL);
    sx_msg.push_back(GS_DT1);
    sx_msg.push_back(GS_ADDR_HI);
    sx_msg.push_back(GS_PART_GRP | 8'($urandom_range(0, 15)));
    sx_msg.push_back(op);
    sx_msg.push_back(val);
    sx_msg.push_back(8'($urandom_range(0, 127)));
    sx_msg.push_back(SX_STOP);
    if ($urandom_range(0, 7) == 0) begin
      sx_msg[$urandom_range(0, 10)] ^= 8'($urandom_range(1, 255));
    end
  endtask

  // result side: random pop stalls per result
  initial begin : pop_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stim
    logic [3:0] ch;
    logic [6:0] d2;
    logic [7:0] val;
    mode_t      m;
    int         n;
    int         k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edge values, ignored statuses, gm2 bank handling, gm2 and xg resets
    send_item(1'b0, 8'h90, 7'd127, 7'd127, 1'b1);
    send_item(1'b0, 8'h8F, 7'd0, 7'd0, 1'b0);
    send_item(1'b0, 8'h7F, 7'd1, 7'd2, 1'b0);
    send_item(1'b0, SX_START, 7'd3, 7'd4, 1'b0);
    send_item(1'b0, 8'hFF, 7'd5, 7'd6, 1'b1);
    send_item(1'b0, {KIND_PROGRAM, 4'd9}, 7'd10, 7'd0, 1'b0);
    send_item(1'b0, {KIND_CONTROL, 4'd3}, 7'd0, XG_DRUM_BANK, 1'b0);
    load_reset(MODE_GM2);
    send_sysex_msg();
    send_item(1'b0, {KIND_CONTROL, 4'd5}, 7'd0, GM2_DRUM_BANK, 1'b0);
    send_item(1'b0, {KIND_CONTROL, 4'd5}, 7'd0, GM2_MELO_BANK, 1'b0);
    send_item(1'b0, {KIND_CONTROL, 4'd9}, 7'd0, GM2_MELO_BANK, 1'b0);
    load_reset(MODE_XG);
    send_sysex_msg();

    // random mix of channel traffic and sysex
    while (items_sent - ignored_sent < 400) begin
      if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
      ch = 4'($urandom_range(0, 15));
      d2 = 7'($urandom);
      case ($urandom_range(0, 15))
        0, 1, 2: begin
          // bank select with the interesting values most of the time
          case ($urandom_range(0, 3))
            0: d2 = XG_DRUM_BANK;
            1: d2 = GM2_DRUM_BANK;
            2: d2 = GM2_MELO_BANK;
            default: ;
          endcase
          send_item(1'b0, {KIND_CONTROL, ch}, 7'd0, d2, 1'($urandom));
        end
        3: send_item(1'b0, {KIND_PROGRAM, ch}, 7'($urandom), d2, 1'($urandom));
        4, 5: send_item(1'b0, 8'($urandom_range(8'h80, 8'hEF)), 7'($urandom), d2,
                        1'($urandom));
        6: begin
          // data byte or system status as a short message
          if ($urandom_range(0, 1)) val = 8'($urandom_range(0, 8'h7F));
          else val = 8'($urandom_range(8'hF0, 8'hFF));
          send_item(1'b0, val, 7'($urandom), d2, 1'($urandom));
          ignored_sent++;
        end
        7: begin
          case ($urandom_range(0, 2))
            0: m = MODE_GM;
            1: m = MODE_GM2;
            default: m = MODE_XG;
          endcase
          load_reset(m);
          send_sysex_msg();
        end
        8, 9: begin
          // gs reset, free address bytes, checksum mostly right
          load_reset(MODE_GS);
          if ($urandom_range(0, 1)) begin
            sx_msg[5] = 8'($urandom);
            sx_msg[6] = 8'($urandom);
          end
          sx_msg[9] = 8'((int'(sx_msg[5]) + int'(sx_msg[6]) + 1) & 127);
          if ($urandom_range(0, 4) == 0) sx_msg[9] ^= 8'($urandom_range(1, 255));
          send_sysex_msg();
        end
        10, 11: begin
          if ($urandom_range(0, 3) == 0) val = 8'($urandom);
          else val = 8'($urandom_range(0, 15));
          build_gs_edit(GS_PART_ASGN, val);
          send_sysex_msg();
        end
        12, 13: begin
          if ($urandom_range(0, 2) == 0) val = 8'd0;
          else val = 8'($urandom);
          build_gs_edit(GS_RHYTHM, val);
          send_sysex_msg();
        end
        14: begin
          // overflow, sometimes past a complete gs reset image
          if ($urandom_range(0, 1)) begin
            load_reset(MODE_GS);
          end else begin
            sx_msg.delete();
            sx_msg.push_back(SX_START);
            for (k = 1; k < STORE_DEPTH; k++) sx_msg.push_back(8'($urandom));
          end
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++) sx_msg.push_back(8'($urandom));
          send_sysex_msg();
        end
        default: begin
          // broken reset images or random short sysex
          if ($urandom_range(0, 1)) begin
            load_reset(mode_t'($urandom_range(0, 3)));
            case ($urandom_range(0, 2))
              0: sx_msg[$urandom_range(0, sx_msg.size() - 1)] ^= 8'($urandom_range(1, 255));
              1: void'(sx_msg.pop_back());
              default: sx_msg.push_back(SX_STOP);
            endcase
          end else begin
            sx_msg.delete();
            n = $urandom_range(1, STORE_DEPTH);
            for (k = 0; k < n; k++) sx_msg.push_back(8'($urandom));
            if ($urandom_range(0, 1)) sx_msg[0] = SX_START;
          end
          send_sysex_msg();
        end
      endcase
    end

    // drain the results, then keep watching for strays
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d items: %0d sysex messages, %0d ignored statuses",
             items_sent, sysex_sent, ignored_sent);
    $display("compared %0d results, %0d of them recognized resets", checked, resets_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #500000;
    $display("FAIL");
    $finish;
  end

endmodule
